/* design/min_max_color_normalizer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the min/max colour normaliser
// Concurrent assertion forms used by the checker file mmcn_checker.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_COLOR_NORMALIZER_ASSERT_SVH
`define MIN_MAX_COLOR_NORMALIZER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MMCN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMCN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/mmcn_pkg.sv */
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared constants and types of the min/max colour normaliser.
// ----------------------------------------------------------------------------
package mmcn_pkg;

   localparam int MAX_POINTS_DEFAULT  = 1024;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int AXES                = 3;
   localparam int QUOT_WIDTH          = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

/* design/mmcn_ram.sv */
// ----------------------------------------------------------------------------
// mmcn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmcn_ram #(
   parameter int DATA_WIDTH = 48,
   parameter int DEPTH      = mmcn_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/min_max_color_normalizer.sv */
// ----------------------------------------------------------------------------
// min_max_color_normalizer
// Stores a point set, tracks per-axis extremes and returns each point's
// colour as (v - min) / (max - min) in unsigned Q0.16.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | opcode, first_point, x/y/z_coord
//  rsp     | out       | rsp_valid/rsp_stall  | red, green, blue, last_color,
//          |           |                      | none_left
//
// A load is accepted while idle. A read runs memory read, operand setup,
// 16 restoring-division steps (one quotient bit per cycle, three axis lanes in
// parallel) and the output load; a read with no point left goes straight to the output load.
// Synchronous reset; the point store has no reset and needs no clearing pass.
// rsp_stall holds the output register; a result waiting there still lets loads
// be accepted, but the next finished read waits in ST_DONE with req_stall high.
// ----------------------------------------------------------------------------
module min_max_color_normalizer #(
   parameter int MAX_POINTS  = mmcn_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = mmcn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic                                 req_first_point,
   input  logic signed [COORD_WIDTH-1:0]        req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]        req_y_coord,
   input  logic signed [COORD_WIDTH-1:0]        req_z_coord,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mmcn_pkg::QUOT_WIDTH-1:0]      rsp_red,
   output logic [mmcn_pkg::QUOT_WIDTH-1:0]      rsp_green,
   output logic [mmcn_pkg::QUOT_WIDTH-1:0]      rsp_blue,
   output logic                                 rsp_last_color,
   output logic                                 rsp_none_left
);

   localparam int CW         = COORD_WIDTH;
   localparam int AXES       = mmcn_pkg::AXES;
   localparam int QW         = mmcn_pkg::QUOT_WIDTH;
   localparam int CNT_WIDTH  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_WIDTH = $clog2(MAX_POINTS);
   localparam int BIT_WIDTH  = $clog2(QW);

   mmcn_pkg::state_type state_ff, state_in;

   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [CNT_WIDTH-1:0]   rpos_ff, rpos_in;
   logic signed [CW-1:0]   min_ff [AXES];
   logic signed [CW-1:0]   min_in [AXES];
   logic signed [CW-1:0]   max_ff [AXES];
   logic signed [CW-1:0]   max_in [AXES];
   logic                   last_ff, last_in;
   logic                   none_ff, none_in;
   logic [CW-1:0]          rem_ff [AXES];
   logic [CW-1:0]          rem_in [AXES];
   logic [CW-1:0]          den_ff [AXES];
   logic [CW-1:0]          den_in [AXES];
   logic [QW-1:0]          quot_ff [AXES];
   logic [QW-1:0]          quot_in [AXES];
   logic                   zero_ff [AXES];
   logic                   zero_in [AXES];
   logic                   sat_ff [AXES];
   logic                   sat_in [AXES];
   logic [BIT_WIDTH-1:0]   bit_ff, bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]          color_ff [AXES];
   logic [QW-1:0]          color_in [AXES];
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_none_ff, rsp_none_in;

   logic signed [CW-1:0]   req_coord [AXES];
   logic                   req_accept;
   logic                   is_load;
   logic                   is_read;
   logic [CNT_WIDTH-1:0]   base_count;
   logic                   store_full;
   logic                   load_ok;
   logic                   has_point;
   logic                   out_free;
   logic [AXES*CW-1:0]     ram_wr_data;
   logic [AXES*CW-1:0]     ram_rd_data;

   assign req_coord[0] = req_x_coord;
   assign req_coord[1] = req_y_coord;
   assign req_coord[2] = req_z_coord;
   assign ram_wr_data  = {req_z_coord, req_y_coord, req_x_coord};

   assign req_stall  = (state_ff != mmcn_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_load    = req_accept && (req_opcode == mmcn_pkg::OP_LOAD);
   assign is_read    = req_accept && (req_opcode == mmcn_pkg::OP_READ);
   assign base_count = req_first_point ? '0 : count_ff;
   assign store_full = (base_count == CNT_WIDTH'(MAX_POINTS));
   assign load_ok    = is_load && !store_full;
   assign has_point  = (rpos_ff < count_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   mmcn_ram #(
      .DATA_WIDTH (AXES * CW),
      .DEPTH      (MAX_POINTS)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (base_count[ADDR_WIDTH-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (is_read),
      .rd_addr (rpos_ff[ADDR_WIDTH-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic signed [CW-1:0] v;
      logic signed [CW:0]   num;
      logic signed [CW:0]   den;
      logic [CW:0]          shifted;
      logic                 ge;

      v            = '0;
      num          = '0;
      den          = '0;
      shifted      = '0;
      ge           = 1'b0;
      state_in     = state_ff;
      count_in     = count_ff;
      rpos_in      = rpos_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      none_in      = none_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      zero_in      = zero_ff;
      sat_in       = sat_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      color_in     = color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;

      case (state_ff)
         mmcn_pkg::ST_IDLE: begin
            if (is_load) begin
               if (req_first_point) begin
                  rpos_in = '0;
               end
               count_in = load_ok ? base_count + 1'b1 : base_count;
               if (load_ok) begin
                  for (int a = 0; a < AXES; a++) begin
                     if (base_count == '0 || req_coord[a] < min_ff[a]) begin
                        min_in[a] = req_coord[a];
                     end
                     if (base_count == '0 || req_coord[a] > max_ff[a]) begin
                        max_in[a] = req_coord[a];
                     end
                  end
               end
            end else if (is_read) begin
               if (has_point) begin
                  rpos_in  = rpos_ff + 1'b1;
                  last_in  = (rpos_ff + 1'b1 == count_ff);
                  none_in  = 1'b0;
                  state_in = mmcn_pkg::ST_CALC;
               end else begin
                  last_in  = 1'b0;
                  none_in  = 1'b1;
                  state_in = mmcn_pkg::ST_DONE;
               end
            end
         end
         mmcn_pkg::ST_CALC: begin
            // operands for the division: (v - min) and (max - min)
            for (int a = 0; a < AXES; a++) begin
               v          = ram_rd_data[a*CW +: CW];
               num        = {v[CW-1], v} - {min_ff[a][CW-1], min_ff[a]};
               den        = {max_ff[a][CW-1], max_ff[a]} - {min_ff[a][CW-1], min_ff[a]};
               zero_in[a] = (max_ff[a] <= min_ff[a]) || (v <= min_ff[a]);
               sat_in[a]  = (v >= max_ff[a]);
               rem_in[a]  = num[CW-1:0];
               den_in[a]  = den[CW-1:0];
               quot_in[a] = '0;
            end
            bit_in   = '0;
            state_in = mmcn_pkg::ST_DIV;
         end
         mmcn_pkg::ST_DIV: begin
            // restoring division, one quotient bit per lane per cycle
            for (int a = 0; a < AXES; a++) begin
               shifted    = {rem_ff[a], 1'b0};
               ge         = (shifted >= {1'b0, den_ff[a]});
               rem_in[a]  = ge ? CW'(shifted - {1'b0, den_ff[a]}) : shifted[CW-1:0];
               quot_in[a] = {quot_ff[a][QW-2:0], ge};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_WIDTH'(QW - 1)) begin
               state_in = mmcn_pkg::ST_DONE;
            end
         end
         mmcn_pkg::ST_DONE: begin
            if (out_free) begin
               for (int a = 0; a < AXES; a++) begin
                  if (none_ff || zero_ff[a]) begin
                     color_in[a] = '0;
                  end else if (sat_ff[a]) begin
                     color_in[a] = '1;
                  end else begin
                     color_in[a] = quot_ff[a];
                  end
               end
               rsp_last_in  = last_ff;
               rsp_none_in  = none_ff;
               rsp_valid_in = 1'b1;
               state_in     = mmcn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmcn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmcn_pkg::ST_IDLE;
         count_ff     <= '0;
         rpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rpos_ff      <= rpos_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      none_ff     <= none_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      zero_ff     <= zero_in;
      sat_ff      <= sat_in;
      bit_ff      <= bit_in;
      color_ff    <= color_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = color_ff[0];
   assign rsp_green      = color_ff[1];
   assign rsp_blue       = color_ff[2];
   assign rsp_last_color = rsp_last_ff;
   assign rsp_none_left  = rsp_none_ff;

endmodule

/* design/mmcn_checker.sv */
// ----------------------------------------------------------------------------
// mmcn_checker
// Port-level checks on the min/max colour normaliser, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_max_color_normalizer_assert.svh"

module mmcn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [mmcn_pkg::QUOT_WIDTH-1:0] rsp_red,
   input logic [mmcn_pkg::QUOT_WIDTH-1:0] rsp_green,
   input logic [mmcn_pkg::QUOT_WIDTH-1:0] rsp_blue,
   input logic                            rsp_last_color,
   input logic                            rsp_none_left
);

   // an empty read carries no colour and cannot be the last point
   `MMCN_ASSERT_SAME(a_none_left_zero, clock, reset, rsp_valid && rsp_none_left, rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && !rsp_last_color, "none_left with non-zero colour")
   `MMCN_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_last_color && rsp_none_left), "last_color and none_left together")
   // loads never stall the request side, reads always occupy the block
   `MMCN_ASSERT_NEXT(a_load_single, clock, reset, req_valid && !req_stall && req_opcode == mmcn_pkg::OP_LOAD, !req_stall, "stall after a load transaction")
   `MMCN_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && !req_stall && req_opcode == mmcn_pkg::OP_READ, req_stall, "no stall after a read transaction")
   `MMCN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "stalled result changed")

endmodule

bind min_max_color_normalizer mmcn_checker u_mmcn_checker (.*);

/* tb/color_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_check
// Watches both channels of the colour normaliser. Keeps its own copy of the
// point set and per-axis extremes, works out each read's colour when the read
// is accepted, and compares every returned colour field by field, in order.
// ----------------------------------------------------------------------------
module color_check #(
   parameter int MAX_POINTS  = mmcn_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = mmcn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_opcode,
   input  logic                               req_first_point,
   input  logic signed [COORD_WIDTH-1:0]      req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]      req_y_coord,
   input  logic signed [COORD_WIDTH-1:0]      req_z_coord,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [mmcn_pkg::QUOT_WIDTH-1:0]    rsp_red,
   input  logic [mmcn_pkg::QUOT_WIDTH-1:0]    rsp_green,
   input  logic [mmcn_pkg::QUOT_WIDTH-1:0]    rsp_blue,
   input  logic                               rsp_last_color,
   input  logic                               rsp_none_left,
   output int                                 errors,
   output int                                 colours_pending,
   output int                                 loads_seen,
   output int                                 loads_dropped,
   output int                                 reads_seen,
   output int                                 empty_reads,
   output int                                 last_reads
);

   localparam int QW = mmcn_pkg::QUOT_WIDTH;

   typedef struct packed {
      logic [QW-1:0] red;
      logic [QW-1:0] green;
      logic [QW-1:0] blue;
      logic          last_color;
      logic          none_left;
   } colour_type;

   int         point_axis [MAX_POINTS][3];
   int         set_size;
   int         next_read;
   int         axis_lo [3];
   int         axis_hi [3];
   colour_type colours_due [$];
   int         mismatch_count = 0;
   int         due_count      = 0;
   int         n_loads        = 0;
   int         n_dropped      = 0;
   int         n_reads        = 0;
   int         n_empty        = 0;
   int         n_last         = 0;

   assign errors          = mismatch_count;
   assign colours_pending = due_count;
   assign loads_seen      = n_loads;
   assign loads_dropped   = n_dropped;
   assign reads_seen      = n_reads;
   assign empty_reads     = n_empty;
   assign last_reads      = n_last;

   // (v - lo) / (hi - lo) in Q0.16, truncated; flat axis gives 0, v at hi saturates
   function automatic logic [QW-1:0] axis_level(input int v, input int lo, input int hi);
      longint span;
      longint q;
      if (hi <= lo || v <= lo) return '0;
      if (v >= hi) return '1;
      span = longint'(hi) - longint'(lo);
      q = ((longint'(v) - longint'(lo)) << QW) / span;
      if (q > 65535) q = 65535;
      return q[QW-1:0];
   endfunction

   task automatic compare_field(input string field, input logic [QW-1:0] want,
                                input logic [QW-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      colour_type got;
      colour_type want;
      int         coord [3];
      if (reset) begin
         set_size  = 0;
         next_read = 0;
         axis_lo   = '{0, 0, 0};
         axis_hi   = '{0, 0, 0};
         colours_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_red, rsp_green, rsp_blue, rsp_last_color, rsp_none_left};
            if (colours_due.size() == 0) begin
               $error("colour transaction arrived with none expected");
               mismatch_count++;
            end else begin
               want = colours_due.pop_front();
               compare_field("red", want.red, got.red);
               compare_field("green", want.green, got.green);
               compare_field("blue", want.blue, got.blue);
               compare_field("last_color", QW'(want.last_color), QW'(got.last_color));
               compare_field("none_left", QW'(want.none_left), QW'(got.none_left));
               if (got.none_left === 1'b1) n_empty++;
               if (got.last_color === 1'b1) n_last++;
            end
         end

         if (req_valid && !req_stall) begin
            if (req_opcode == mmcn_pkg::OP_LOAD) begin
               coord[0] = int'(req_x_coord);
               coord[1] = int'(req_y_coord);
               coord[2] = int'(req_z_coord);
               n_loads++;
               if (req_first_point) begin
                  set_size  = 0;
                  next_read = 0;
               end
               if (set_size >= MAX_POINTS) begin
                  n_dropped++;
               end else begin
                  for (int a = 0; a < 3; a++) begin
                     if (set_size == 0 || coord[a] < axis_lo[a]) axis_lo[a] = coord[a];
                     if (set_size == 0 || coord[a] > axis_hi[a]) axis_hi[a] = coord[a];
                     point_axis[set_size][a] = coord[a];
                  end
                  set_size++;
               end
            end else begin
               n_reads++;
               want = '0;
               if (next_read >= set_size) begin
                  want.none_left = 1'b1;
               end else begin
                  want.red   = axis_level(point_axis[next_read][0], axis_lo[0], axis_hi[0]);
                  want.green = axis_level(point_axis[next_read][1], axis_lo[1], axis_hi[1]);
                  want.blue  = axis_level(point_axis[next_read][2], axis_lo[2], axis_hi[2]);
                  want.last_color = (next_read + 1 == set_size);
                  next_read++;
               end
               colours_due = {colours_due, want};
            end
         end
      end
      due_count = colours_due.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and read transactions into the colour normaliser: a directed
// opening, random point sets under three idling mixes, and a full-store run
// with overflow. color_check predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CW        = mmcn_pkg::COORD_WIDTH_DEFAULT;
   localparam int QW        = mmcn_pkg::QUOT_WIDTH;
   localparam int COORD_MIN = -(2 ** (CW - 1));
   localparam int COORD_MAX = (2 ** (CW - 1)) - 1;

   typedef enum {AX_FULL, AX_NEAR, AX_EDGE, AX_FLAT} axis_mode_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_opcode      = mmcn_pkg::OP_LOAD;
   logic                 req_first_point = 1'b0;
   logic signed [CW-1:0] req_x_coord     = '0;
   logic signed [CW-1:0] req_y_coord     = '0;
   logic signed [CW-1:0] req_z_coord     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [QW-1:0]        rsp_red;
   logic [QW-1:0]        rsp_green;
   logic [QW-1:0]        rsp_blue;
   logic                 rsp_last_color;
   logic                 rsp_none_left;

   int errors;
   int colours_pending;
   int loads_seen;
   int loads_dropped;
   int reads_seen;
   int empty_reads;
   int last_reads;

   int gap_pct    = 15;
   int stall_pct  = 52;
   int items_sent = 0;

   min_max_color_normalizer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_first_point (req_first_point),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_color  (rsp_last_color),
      .rsp_none_left   (rsp_none_left)
   );

   color_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_first_point (req_first_point),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_color  (rsp_last_color),
      .rsp_none_left   (rsp_none_left),
      .errors          (errors),
      .colours_pending (colours_pending),
      .loads_seen      (loads_seen),
      .loads_dropped   (loads_dropped),
      .reads_seen      (reads_seen),
      .empty_reads     (empty_reads),
      .last_reads      (last_reads)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int pick_coord(input axis_mode_type m, input int base);
      int v;
      case (m)
         AX_FULL: v = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
         AX_NEAR: begin
            v = base + int'($urandom_range(3));
            if (v > COORD_MAX) v = COORD_MAX;
         end
         AX_EDGE: begin
            case ($urandom_range(5))
               0:       v = COORD_MIN;
               1:       v = COORD_MAX;
               2:       v = COORD_MIN + 1;
               3:       v = COORD_MAX - 1;
               4:       v = 0;
               default: v = -1;
            endcase
         end
         default: v = base;
      endcase
      return v;
   endfunction

   // one transaction, with random idle cycles in front at the current rate
   task automatic send_item(input logic op, input logic first,
                            input int x, y, z);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_first_point <= first;
      req_x_coord     <= CW'(x);
      req_y_coord     <= CW'(y);
      req_z_coord     <= CW'(z);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // payload of a read is ignored, so it carries noise
   task automatic read_colour();
      send_item(mmcn_pkg::OP_READ, 1'($urandom_range(1)), int'($urandom), int'($urandom),
                int'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (colours_pending != 0);
   endtask

   task automatic play_sets(input int budget);
      int            stop_at;
      int            n;
      int            reads;
      axis_mode_type mode [3];
      int            base [3];
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 10) begin
            send_item(1'($urandom_range(1)), $urandom_range(7) == 0, int'($urandom),
                      int'($urandom), int'($urandom));
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
            for (int a = 0; a < 3; a++) begin
               mode[a] = axis_mode_type'($urandom_range(3));
               base[a] = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
            end
            for (int i = 0; i < n; i++) begin
               send_item(mmcn_pkg::OP_LOAD, i == 0, pick_coord(mode[0], base[0]),
                         pick_coord(mode[1], base[1]), pick_coord(mode[2], base[2]));
            end
            // mostly read the whole set, sometimes past its end; sometimes abandon early
            reads = ($urandom_range(4) == 0) ? $urandom_range(n) : n + $urandom_range(2);
            for (int i = 0; i < reads; i++) begin
               if ($urandom_range(99) < 8) begin
                  send_item(mmcn_pkg::OP_LOAD, 1'b0, pick_coord(AX_FULL, 0),
                            pick_coord(AX_EDGE, 0), pick_coord(mode[2], base[2]));
               end
               read_colour();
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b1, COORD_MIN, COORD_MAX, 0);
      read_colour();
      read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b1, COORD_MIN, COORD_MIN, 5);
      send_item(mmcn_pkg::OP_LOAD, 1'b0, COORD_MAX, COORD_MAX, 5);
      send_item(mmcn_pkg::OP_LOAD, 1'b0, 0, 1, 5);
      send_item(mmcn_pkg::OP_LOAD, 1'b0, -1, COORD_MAX - 1, 5);
      repeat (5) read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b0, 7, -7, 6);
      read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b1, 0, 0, 0);
      send_item(mmcn_pkg::OP_LOAD, 1'b0, 10, 10, 10);
      read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b0, 20, -10, 10);
      read_colour();
      read_colour();

      play_sets(90);
      wait_drained();

      gap_pct   = 52;
      stall_pct = 15;
      play_sets(90);
      wait_drained();

      gap_pct   = 0;
      stall_pct = 0;
      play_sets(80);

      // fill the store, then overflow it with points that would move the extremes
      send_item(mmcn_pkg::OP_LOAD, 1'b1, int'($urandom_range(2000)) - 1000,
                int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000);
      for (int i = 1; i < mmcn_pkg::MAX_POINTS_DEFAULT; i++) begin
         send_item(mmcn_pkg::OP_LOAD, 1'b0, int'($urandom_range(2000)) - 1000,
                   int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000);
      end
      repeat (2) send_item(mmcn_pkg::OP_LOAD, 1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
      repeat (40) read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b0, COORD_MAX, COORD_MIN, COORD_MAX);
      read_colour();
      send_item(mmcn_pkg::OP_LOAD, 1'b1, 3, 3, 3);
      read_colour();
      read_colour();

      wait_drained();
      repeat (40) @(posedge clock);

      $display("Covered %0d loads (%0d dropped on a full store) and %0d colour reads.",
               loads_seen, loads_dropped, reads_seen);
      $display("%0d reads found nothing left, %0d returned the last point of a set.",
               empty_reads, last_reads);
      if (errors == 0 && colours_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout with %0d colours outstanding", colours_pending);
      $display("FAILURE");
      $finish;
   end

endmodule
